/* hw/rtl/trapezoid_roi_crop_gray_binarize_unit_macros.svh */
// ----------------------------------------------------------------------------
// trapezoid roi crop assertion macros
// wrappers for concurrent checks, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_ROI_CROP_GRAY_BINARIZE_UNIT_MACROS_SVH
`define TRAPEZOID_ROI_CROP_GRAY_BINARIZE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TRCGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TRCGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TRCGB_ASSERT(lbl, prop, msg)
`define TRCGB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/trcgb_pkg.sv */
// ----------------------------------------------------------------------------
// trcgb_pkg
// shared widths, register indexes, pixel constants and sequencer states
// ----------------------------------------------------------------------------
package trcgb_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ROWS_W     = 13;
  localparam int unsigned POINT_W    = 24;
  localparam int unsigned CROP_W     = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned EDGE_W = COORD_W + 1;
  localparam int unsigned PROD_W = 2 * EDGE_W;
  localparam int unsigned NUM_W  = PROD_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MID_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH = 3'd6;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY = 2'd1;

  localparam int unsigned GRAY_SUM_W   = 15;
  localparam int unsigned GRAY_RECIP_W = 15;
  localparam int unsigned GRAY_PROD_W  = GRAY_SUM_W + GRAY_RECIP_W;
  localparam int unsigned GRAY_SHIFT   = 21;
  localparam logic [GRAY_SUM_W-1:0]   GRAY_WR    = 15'd21;
  localparam logic [GRAY_SUM_W-1:0]   GRAY_WG    = 15'd72;
  localparam logic [GRAY_SUM_W-1:0]   GRAY_WB    = 15'd7;
  localparam logic [GRAY_RECIP_W-1:0] GRAY_RECIP = 15'd20972;

  localparam logic [PIX_W-1:0] BIN_THRESH = 8'd128;
  localparam logic [PIX_W-1:0] BIN_HIGH   = 8'd255;
  localparam logic [PIX_W-1:0] BIN_LOW    = 8'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GRAY,
    ST_MUL0,
    ST_MUL1,
    ST_DSTART,
    ST_DWAIT,
    ST_EMIT
  } state_e;

endpackage

/* hw/rtl/trcgb_div.sv */
// ----------------------------------------------------------------------------
// trcgb_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module trcgb_div
  import trcgb_pkg::*;
#(
  parameter int unsigned N_W = NUM_W,
  parameter int unsigned D_W = EDGE_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [N_W-1:0] num_i,
  input  logic signed [D_W-1:0] den_i,
  output logic                  done_o,
  output logic signed [N_W-1:0] quot_o
);

  localparam int unsigned MAG_W  = N_W - 1;
  localparam int unsigned DMAG_W = D_W - 1;
  localparam int unsigned CNT_W  = $clog2(MAG_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DMAG_W-1:0] rem_q, rem_d;
  logic [DMAG_W-1:0] dvs_q, dvs_d;
  logic [MAG_W-1:0]  quo_q, quo_d;
  logic              neg_q, neg_d;

  logic [N_W-1:0]    num_abs;
  logic [D_W-1:0]    den_abs;
  logic [DMAG_W:0]   trial;
  logic [DMAG_W:0]   diff;
  logic              ge;

  assign num_abs = num_i[N_W-1] ? N_W'(-num_i) : N_W'(num_i);
  assign den_abs = den_i[D_W-1] ? D_W'(-den_i) : D_W'(den_i);
  assign trial   = {rem_q, quo_q[MAG_W-1]};
  assign diff    = trial - {1'b0, dvs_q};
  assign ge      = ~diff[DMAG_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MAG_W - 1);
      rem_d  = '0;
      dvs_d  = den_abs[DMAG_W-1:0];
      quo_d  = num_abs[MAG_W-1:0];
      neg_d  = num_i[N_W-1] ^ den_i[D_W-1];
    end else if (busy_q) begin
      rem_d = ge ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
      quo_d = {quo_q[MAG_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

/* hw/rtl/trcgb_gray.sv */
// ----------------------------------------------------------------------------
// trcgb_gray
// two-stage rgb to gray: weighted sum, then divide by 100 via reciprocal
// ----------------------------------------------------------------------------
module trcgb_gray
  import trcgb_pkg::*;
(
  input  logic             clk_i,
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  output logic [PIX_W-1:0] gray_o
);

  logic [GRAY_SUM_W-1:0]  sum_d, sum_q;
  logic [GRAY_PROD_W-1:0] prod;
  logic [PIX_W-1:0]       gray_q;

  assign sum_d = GRAY_WR * GRAY_SUM_W'(red_i) + GRAY_WG * GRAY_SUM_W'(green_i)
               + GRAY_WB * GRAY_SUM_W'(blue_i);
  assign prod  = GRAY_PROD_W'(sum_q) * GRAY_PROD_W'(GRAY_RECIP);

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    gray_q <= prod[GRAY_SHIFT +: PIX_W];
  end

  assign gray_o = gray_q;

endmodule

/* hw/rtl/trapezoid_roi_crop_gray_binarize_unit.sv */
// ----------------------------------------------------------------------------
// trapezoid_roi_crop_gray_binarize_unit
// crops a pixel stream to a trapezoid region, pass, gray or binary output
//
//   channel  signals                                  direction
//   in       in_valid_i in_ready_o pixel_* *_chan_i   item in
//   out      out_valid_o out_ready_i out_*            item out
//   cfg      cfg_we_i cfg_idx_i cfg_wdata_i           register write
//
// an item passes check, gray and emit from accept back to ready when its row span
// is cached or not needed (flat side), a dropped item check alone; a top row seen
// first runs mul0, mul1, dstart and dwait per edge, left then right, on the
// shared multiplier and bit-serial divider, then emit; no clearing pass after reset
// the result waits in the output register and the next item is taken meanwhile
// an item stalls in its emit state while that register is full and not read
// ----------------------------------------------------------------------------
`include "trapezoid_roi_crop_gray_binarize_unit_macros.svh"

module trapezoid_roi_crop_gray_binarize_unit
  import trcgb_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_W-1:0]    pixel_col_i,
  input  logic [COORD_W-1:0]    pixel_row_i,
  input  logic [PIX_W-1:0]      blue_or_gray_i,
  input  logic [PIX_W-1:0]      green_chan_i,
  input  logic [PIX_W-1:0]      red_chan_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_W-1:0]    out_col_o,
  output logic [COORD_W-1:0]    out_row_o,
  output logic [PIX_W-1:0]      pixel_value_o
);

  localparam int unsigned SPAN_W = $clog2(MAX_DIM + 2);
  localparam int unsigned CMP_W  = (SPAN_W > COORD_W + 1) ? SPAN_W : COORD_W + 1;
  localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(MAX_DIM + 1);

  // configuration
  logic [MODE_W-1:0]  mode_q;
  logic [ROWS_W-1:0]  rows_q;
  logic [POINT_W-1:0] ml_q, tl_q, tr_q, mr_q;
  logic [CROP_W-1:0]  crop_q;
  logic               cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= REG_CROP_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
      rows_q <= ROWS_RESET;
      ml_q   <= '0;
      tl_q   <= '0;
      tr_q   <= '0;
      mr_q   <= '0;
      crop_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OUT_MODE:   mode_q <= cfg_wdata_i[MODE_W-1:0];
        REG_IMAGE_ROWS: rows_q <= cfg_wdata_i[ROWS_W-1:0];
        REG_MID_LEFT:   ml_q   <= cfg_wdata_i[POINT_W-1:0];
        REG_TOP_LEFT:   tl_q   <= cfg_wdata_i[POINT_W-1:0];
        REG_TOP_RIGHT:  tr_q   <= cfg_wdata_i[POINT_W-1:0];
        REG_MID_RIGHT:  mr_q   <= cfg_wdata_i[POINT_W-1:0];
        REG_CROP_WIDTH: crop_q <= cfg_wdata_i[CROP_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  logic [COORD_W-1:0] col_q, row_q;
  logic [PIX_W-1:0]   blu_q, grn_q, red_q;
  logic               in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
      blu_q <= blue_or_gray_i;
      grn_q <= green_chan_i;
      red_q <= red_chan_i;
    end
  end

  // gray unit
  logic [PIX_W-1:0] gray;

  trcgb_gray u_gray (
    .clk_i   (clk_i),
    .red_i   (red_q),
    .green_i (grn_q),
    .blue_i  (blu_q),
    .gray_o  (gray)
  );

  // region decode
  logic [COORD_W-1:0] y_ml, y_tl, y_tr, ymin;
  logic               drop, top_row, hit;
  logic signed [EDGE_W-1:0] den_l, den_r;

  assign y_ml = ml_q[COORD_W-1:0];
  assign y_tl = tl_q[COORD_W-1:0];
  assign y_tr = tr_q[COORD_W-1:0];
  assign ymin = (y_tl < y_tr) ? y_tr : y_tl;

  assign drop    = (row_q < ymin) || ({1'b0, row_q} >= rows_q) || ({1'b0, col_q} >= crop_q);
  assign top_row = row_q < y_ml;

  assign den_l = $signed({1'b0, y_tl}) - $signed({1'b0, y_ml});
  assign den_r = $signed({1'b0, y_tr}) - $signed({1'b0, mr_q[COORD_W-1:0]});

  // edge datapath, shared multiplier and divider
  state_e state_q, state_d;
  logic   side_q, side_d;
  logic   top_q, top_d;

  logic [POINT_W-1:0]       mid_sel, tp_sel;
  logic signed [EDGE_W-1:0] x1, y1, x2, y2, den_e, dx, dy;
  logic signed [EDGE_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p, prod_q;
  logic signed [NUM_W-1:0]  num_q;
  logic signed [NUM_W-1:0]  quot;
  logic                     div_done;
  logic [SPAN_W-1:0]        edge_x;

  assign mid_sel = side_q ? mr_q : ml_q;
  assign tp_sel  = side_q ? tr_q : tl_q;
  assign x1 = $signed({1'b0, mid_sel[POINT_W-1:COORD_W]});
  assign y1 = $signed({1'b0, mid_sel[COORD_W-1:0]});
  assign x2 = $signed({1'b0, tp_sel[POINT_W-1:COORD_W]});
  assign y2 = $signed({1'b0, tp_sel[COORD_W-1:0]});
  assign den_e = y2 - y1;
  assign dx    = x2 - x1;
  assign dy    = $signed({1'b0, row_q}) - y1;

  assign mul_a = (state_q == ST_MUL0) ? x1 : dy;
  assign mul_b = (state_q == ST_MUL0) ? den_e : dx;
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL0) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_MUL1) begin
      num_q <= $signed({prod_q[PROD_W-1], prod_q}) + $signed({mul_p[PROD_W-1], mul_p});
    end
  end

  trcgb_div #(
    .N_W (NUM_W),
    .D_W (EDGE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DSTART),
    .num_i   (num_q),
    .den_i   (den_e),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    if (quot[NUM_W-1]) begin
      edge_x = '0;
    end else if (quot > $signed(NUM_W'(MAX_DIM + 1))) begin
      edge_x = SPAN_MAX;
    end else begin
      edge_x = quot[SPAN_W-1:0];
    end
  end

  // row span cache
  logic [COORD_W-1:0] bounds_row_q, bounds_row_d;
  logic               bounds_valid_q, bounds_valid_d;
  logic [SPAN_W-1:0]  span_first_q, span_first_d;
  logic [SPAN_W-1:0]  span_last_q, span_last_d;

  assign hit = bounds_valid_q && (bounds_row_q == row_q);

  // pass test and pixel value
  logic [CMP_W-1:0] colx, sf, sl;
  logic             pass;
  logic [PIX_W-1:0] val;
  logic             slot_free;

  assign colx = CMP_W'(col_q);
  assign sf   = CMP_W'(span_first_q);
  assign sl   = CMP_W'(span_last_q);

  always_comb begin
    if (!top_q) begin
      pass = 1'b1;
    end else if (sf == sl) begin
      pass = (CMP_W'(colx + CMP_W'(1)) == sf);
    end else begin
      pass = (colx >= sf) && (colx < sl);
    end
    if (!pass) begin
      val = BIN_LOW;
    end else if (mode_q == MODE_PASS) begin
      val = blu_q;
    end else if (mode_q == MODE_GRAY) begin
      val = gray;
    end else begin
      val = (gray < BIN_THRESH) ? BIN_LOW : BIN_HIGH;
    end
  end

  // output register
  logic               out_valid_q;
  logic [COORD_W-1:0] out_col_q, out_row_q;
  logic [PIX_W-1:0]   out_val_q;
  logic               emit;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = (state_q == ST_EMIT) && slot_free;

  // sequencer
  always_comb begin
    state_d        = state_q;
    side_d         = side_q;
    top_d          = top_q;
    bounds_row_d   = bounds_row_q;
    bounds_valid_d = bounds_valid_q;
    span_first_d   = span_first_q;
    span_last_d    = span_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        top_d = top_row;
        if (drop) begin
          state_d = ST_IDLE;
        end else if (top_row && !hit) begin
          if (den_l == '0 || den_r == '0) begin
            span_first_d   = SPAN_W'(1);
            span_last_d    = '0;
            bounds_row_d   = row_q;
            bounds_valid_d = 1'b1;
            state_d        = ST_GRAY;
          end else begin
            side_d  = 1'b0;
            state_d = ST_MUL0;
          end
        end else begin
          state_d = ST_GRAY;
        end
      end
      ST_GRAY:   state_d = ST_EMIT;
      ST_MUL0:   state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          if (!side_q) begin
            span_first_d = edge_x;
            side_d       = 1'b1;
            state_d      = ST_MUL0;
          end else begin
            span_last_d    = edge_x;
            bounds_row_d   = row_q;
            bounds_valid_d = 1'b1;
            state_d        = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_hit) begin
      bounds_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      side_q         <= 1'b0;
      top_q          <= 1'b0;
      bounds_row_q   <= '0;
      bounds_valid_q <= 1'b0;
      span_first_q   <= '0;
      span_last_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      side_q         <= side_d;
      top_q          <= top_d;
      bounds_row_q   <= bounds_row_d;
      bounds_valid_q <= bounds_valid_d;
      span_first_q   <= span_first_d;
      span_last_q    <= span_last_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_col_q <= col_q;
      out_row_q <= row_q - ymin;
      out_val_q <= val;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_col_o     = out_col_q;
  assign out_row_o     = out_row_q;
  assign pixel_value_o = out_val_q;

  // checks
  `TRCGB_ASSERT(a_div_done_in_wait, div_done |-> state_q == ST_DWAIT, "divider done outside wait")
  `TRCGB_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q) == ST_EMIT, "result not from emit")
  `TRCGB_ASSERT(a_span_cached, (state_q == ST_EMIT) && top_q |-> bounds_valid_q && (bounds_row_q == row_q), "top row emitted without span")
  `TRCGB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

/* tb/trapezoid_roi_crop_gray_binarize_unit_test.sv */
// ----------------------------------------------------------------------------
// trapezoid_roi_crop_gray_binarize_unit_test
// drives pixel items through the trapezoid crop unit under several region
// settings and output modes, predicts each cropped item in a scoreboard and
// checks every output item against it, with random gaps on both channels
// ----------------------------------------------------------------------------
module trapezoid_roi_crop_gray_binarize_unit_test
  import trcgb_pkg::*;
();

  localparam logic [MODE_W-1:0]    MODE_BIN     = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;
  localparam int                   DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   red;
  } pixel_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   value;
  } crop_out_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ROWS_W-1:0]  rows;
    logic [POINT_W-1:0] ml;
    logic [POINT_W-1:0] tl;
    logic [POINT_W-1:0] tr;
    logic [POINT_W-1:0] mr;
    logic [CROP_W-1:0]  crop;
  } roi_setting_t;

  class crop_scoreboard;
    logic [MODE_W-1:0]  mode;
    logic [ROWS_W-1:0]  rows;
    logic [POINT_W-1:0] mid_l;
    logic [POINT_W-1:0] top_l;
    logic [POINT_W-1:0] top_r;
    logic [POINT_W-1:0] mid_r;
    logic [CROP_W-1:0]  crop_w;
    logic [COORD_W-1:0] span_row;
    bit                 span_ok;
    logic [EDGE_W-1:0]  span_lo;
    logic [EDGE_W-1:0]  span_hi;
    crop_out_t          cropped[$];
    int                 errors;

    function new();
      mode     = MODE_PASS;
      rows     = ROWS_RESET;
      mid_l    = '0;
      top_l    = '0;
      top_r    = '0;
      mid_r    = '0;
      crop_w   = '0;
      span_row = '0;
      span_ok  = 1'b0;
      span_lo  = '0;
      span_hi  = '0;
      errors   = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function int pending();
      return cropped.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OUT_MODE:   mode   = data[MODE_W-1:0];
        REG_IMAGE_ROWS: rows   = data[ROWS_W-1:0];
        REG_MID_LEFT:   mid_l  = data;
        REG_TOP_LEFT:   top_l  = data;
        REG_TOP_RIGHT:  top_r  = data;
        REG_MID_RIGHT:  mid_r  = data;
        REG_CROP_WIDTH: crop_w = data[CROP_W-1:0];
        default: return;
      endcase
      span_ok = 1'b0;
    endfunction

    // x of the line through mid and top at this row, truncated toward zero
    function bit edge_x(logic [POINT_W-1:0] mid, logic [POINT_W-1:0] top,
                        logic [COORD_W-1:0] row, output logic [EDGE_W-1:0] x);
      longint x1, y1, x2, y2, den, q;
      x1  = longint'(mid[23:12]);
      y1  = longint'(mid[11:0]);
      x2  = longint'(top[23:12]);
      y2  = longint'(top[11:0]);
      den = y2 - y1;
      x   = '0;
      if (den == 0) return 1'b0;
      q = (x1 * den + (longint'(row) - y1) * (x2 - x1)) / den;
      if (q < 0) x = '0;
      else if (q > longint'(MAX_DIM_DEF) + 1) x = 13'd4097;
      else x = EDGE_W'(q);
      return 1'b1;
    endfunction

    function void take_pixel(pixel_in_t px);
      logic [COORD_W-1:0] ymin;
      logic [EDGE_W-1:0]  col_x, a, b;
      bit                 okl, okr, pass;
      int                 gray;
      crop_out_t          res;
      ymin  = (top_l[11:0] < top_r[11:0]) ? top_r[11:0] : top_l[11:0];
      col_x = {1'b0, px.col};
      if (px.row < ymin || {1'b0, px.row} >= rows || col_x >= crop_w) return;
      pass = 1'b1;
      if (px.row < mid_l[11:0]) begin
        if (!span_ok || span_row != px.row) begin
          okl      = edge_x(mid_l, top_l, px.row, a);
          okr      = edge_x(mid_r, top_r, px.row, b);
          span_lo  = (okl && okr) ? a : 13'd1;
          span_hi  = (okl && okr) ? b : 13'd0;
          span_row = px.row;
          span_ok  = 1'b1;
        end
        if (span_lo == span_hi) pass = (col_x + 13'd1 == span_lo);
        else pass = (col_x >= span_lo && col_x < span_hi);
      end
      gray    = (21 * int'(px.red) + 72 * int'(px.green) + 7 * int'(px.blue)) / 100;
      res.col = px.col;
      res.row = px.row - ymin;
      if (!pass) res.value = '0;
      else if (mode == MODE_PASS) res.value = px.blue;
      else if (mode == MODE_GRAY) res.value = PIX_W'(gray);
      else res.value = (gray < 128) ? BIN_LOW : BIN_HIGH;
      cropped.push_back(res);
    endfunction

    function void match_cropped(crop_out_t got);
      crop_out_t want;
      if (cropped.size() == 0) begin
        flag($sformatf("unexpected item: col %0d row %0d value %0d",
                       got.col, got.row, got.value));
        return;
      end
      want = cropped.pop_front();
      if (got.col !== want.col || got.row !== want.row || got.value !== want.value)
        flag($sformatf("item mismatch: exp col %0d row %0d value %0d, got %0d %0d %0d",
                       want.col, want.row, want.value, got.col, got.row, got.value));
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [COORD_W-1:0]    pixel_col_i    = '0;
  logic [COORD_W-1:0]    pixel_row_i    = '0;
  logic [PIX_W-1:0]      blue_or_gray_i = '0;
  logic [PIX_W-1:0]      green_chan_i   = '0;
  logic [PIX_W-1:0]      red_chan_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [COORD_W-1:0]    out_col_o;
  logic [COORD_W-1:0]    out_row_o;
  logic [PIX_W-1:0]      pixel_value_o;

  crop_scoreboard sb = new();
  int tx_idle_pct = 28;
  int rx_idle_pct = 54;
  int sent_count  = 0;

  trapezoid_roi_crop_gray_binarize_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_col_i   (pixel_col_i),
    .pixel_row_i   (pixel_row_i),
    .blue_or_gray_i(blue_or_gray_i),
    .green_chan_i  (green_chan_i),
    .red_chan_i    (red_chan_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .pixel_value_o (pixel_value_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.match_cropped({out_col_o, out_row_o, pixel_value_o});
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic logic [POINT_W-1:0] pt(int x, int y);
    return {x[11:0], y[11:0]};
  endfunction

  function automatic pixel_in_t pix(int col, int row, int b, int g, int r);
    return {col[11:0], row[11:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  function automatic logic [PIX_W-1:0] rand_chan();
    if ($urandom_range(7) == 0) return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom);
  endfunction

  function automatic pixel_in_t rand_pixel(int col, int row);
    pixel_in_t px;
    px.col   = col[11:0];
    px.row   = row[11:0];
    px.blue  = rand_chan();
    px.green = rand_chan();
    px.red   = rand_chan();
    return px;
  endfunction

  function automatic roi_setting_t random_setting();
    roi_setting_t s;
    int h;
    s.mode = MODE_W'($urandom_range(3));
    if ($urandom_range(7) == 0) begin
      s.ml   = POINT_W'($urandom);
      s.tl   = POINT_W'($urandom);
      s.tr   = POINT_W'($urandom);
      s.mr   = POINT_W'($urandom);
      s.rows = ($urandom_range(1) == 1) ? ROWS_RESET : ROWS_W'($urandom_range(1, 4096));
      s.crop = CROP_W'($urandom_range(0, 4096));
    end else begin
      h      = $urandom_range(8, 72);
      s.rows = ROWS_W'(h);
      s.tl   = pt($urandom_range(0, 40), $urandom_range(0, h / 3));
      s.tr   = pt($urandom_range(16, 70), $urandom_range(0, h / 3));
      s.ml   = pt($urandom_range(0, 30), $urandom_range(h / 3, h));
      s.mr   = pt($urandom_range(30, 90), $urandom_range(h / 3, h));
      s.crop = CROP_W'($urandom_range(1, 80));
      if ($urandom_range(9) == 0) s.crop = ($urandom_range(1) == 1) ? 13'd0 : 13'd4096;
      if ($urandom_range(9) == 0) s.rows = ($urandom_range(1) == 1) ? 13'd1 : ROWS_RESET;
    end
    return s;
  endfunction

  task automatic send_pixel(pixel_in_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_col_i    <= px.col;
    pixel_row_i    <= px.row;
    blue_or_gray_i <= px.blue;
    green_chan_i   <= px.green;
    red_chan_i     <= px.red;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_pixel(px);
    sent_count++;
  endtask

  // wait until all items are out and the unit has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic program_roi(roi_setting_t s, bit poke_spare);
    settle();
    write_reg(REG_OUT_MODE, CFG_DATA_W'(s.mode));
    write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(s.rows));
    write_reg(REG_MID_LEFT, s.ml);
    write_reg(REG_TOP_LEFT, s.tl);
    write_reg(REG_TOP_RIGHT, s.tr);
    write_reg(REG_MID_RIGHT, s.mr);
    write_reg(REG_CROP_WIDTH, CFG_DATA_W'(s.crop));
    if (poke_spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // mostly short raster runs in and just around the kept rows, some stray pixels
  task automatic send_run(roi_setting_t s);
    int ymin, ymid, row, col, len;
    ymin = (s.tl[11:0] < s.tr[11:0]) ? int'(s.tr[11:0]) : int'(s.tl[11:0]);
    ymid = int'(s.ml[11:0]);
    if ($urandom_range(99) < 12) begin
      send_pixel(rand_pixel($urandom_range(4095), $urandom_range(4095)));
    end else begin
      if (ymid > ymin && $urandom_range(1) == 1) row = $urandom_range(ymin, ymid - 1);
      else row = $urandom_range((ymin > 0) ? ymin - 1 : 0, int'(s.rows));
      if (row > 4095) row = 4095;
      col = $urandom_range(0, int'(s.crop) + 1);
      len = $urandom_range(1, 6);
      repeat (len) begin
        if (col > 4095) col = 4095;
        send_pixel(rand_pixel(col, row));
        col++;
      end
    end
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int quota);
    roi_setting_t s;
    int goal, runs;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = sent_count + quota;
    while (sent_count < goal) begin
      s = random_setting();
      program_roi(s, $urandom_range(9) == 0);
      runs = 0;
      while (runs < 30 && sent_count < goal) begin
        send_run(s);
        runs++;
      end
    end
  endtask

  task automatic directed_part();
    program_roi('{MODE_GRAY, 13'd64, pt(2, 20), pt(10, 4), pt(30, 6), pt(38, 20), 13'd40},
                1'b0);
    send_pixel(pix(12, 5, 1, 1, 1));
    send_pixel(pix(0, 6, 255, 255, 255));
    send_pixel(pix(20, 6, 10, 200, 90));
    send_pixel(pix(39, 6, 0, 0, 0));
    send_pixel(pix(40, 6, 9, 9, 9));
    send_pixel(pix(39, 20, 255, 255, 255));
    send_pixel(pix(0, 63, 1, 2, 3));
    send_pixel(pix(0, 64, 4, 5, 6));

    // both edges on one line, only the column left of it passes
    program_roi('{MODE_BIN, 13'd32, pt(20, 30), pt(20, 0), pt(20, 0), pt(20, 30), 13'd4096},
                1'b0);
    send_pixel(pix(19, 3, 128, 128, 128));
    send_pixel(pix(19, 4, 127, 127, 127));
    send_pixel(pix(20, 3, 255, 255, 255));
    send_pixel(pix(4095, 31, 255, 255, 255));

    // flat right edge, top rows have no span; spare mode and spare index
    program_roi('{MODE_SPARE, 13'd16, pt(0, 12), pt(5, 2), pt(50, 5), pt(60, 5), 13'd4096},
                1'b1);
    send_pixel(pix(10, 6, 200, 200, 200));
    send_pixel(pix(10, 12, 200, 200, 200));

    program_roi('{MODE_PASS, ROWS_RESET, pt(4095, 4095), pt(0, 0), pt(4095, 0), pt(0, 4095),
                  13'd4096}, 1'b0);
    send_pixel(pix(0, 0, 255, 0, 0));
    send_pixel(pix(4095, 4095, 0, 255, 255));
    send_pixel(pix(4095, 4094, 170, 85, 15));
    send_pixel(pix(2048, 2048, 85, 170, 240));

    // right edge leaves the image below its top row
    program_roi('{MODE_GRAY, ROWS_RESET, pt(0, 4000), pt(0, 0), pt(4095, 3000), pt(0, 3001),
                  13'd4096}, 1'b0);
    send_pixel(pix(4094, 3000, 255, 255, 255));
    send_pixel(pix(4095, 3000, 255, 255, 255));
    send_pixel(pix(0, 3500, 255, 255, 255));
    send_pixel(pix(7, 2999, 255, 255, 255));

    program_roi('{MODE_PASS, 13'd1, pt(0, 0), pt(0, 0), pt(0, 0), pt(0, 0), 13'd0}, 1'b0);
    send_pixel(pix(0, 0, 77, 0, 0));
    program_roi('{MODE_PASS, 13'd1, pt(0, 0), pt(0, 0), pt(0, 0), pt(0, 0), 13'd4096}, 1'b0);
    send_pixel(pix(4095, 0, 77, 0, 0));
  endtask

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed_part();
    run_phase(28, 54, 226);
    run_phase(54, 28, 225);
    run_phase(0, 0, 225);
    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
